FILE: hw/rtl/mstts_pkg.sv
// Shared types and constants of the multi-slot tick task scheduler.
package mstts_pkg;

    // Deadline code for a disarmed slot; also the wrap point of the tick counter
    localparam logic [31:0] ALL_ONES = 32'hFFFF_FFFF;

    // Widths of the stream payload
    localparam int KIND_W     = 2;
    localparam int IDX_W      = 4;
    localparam int TIME_W     = 32;
    localparam int COUNT_W    = 16;
    localparam int MASK_W     = 16;
    localparam int S_TDATA_W  = 72;
    localparam int M_TDATA_W  = 80;
    // Width used to compare a request's slot number with a chain position
    localparam int SLOT_CMP_W = 8;

    // Request kinds
    typedef enum logic [KIND_W-1:0] {
        KIND_TICK  = 2'd0,
        KIND_SCHED = 2'd1,
        KIND_STOP  = 2'd2,
        KIND_ACK   = 2'd3
    } kind_t;

    // One slot's state, as it travels around the chain
    typedef struct packed {
        logic [TIME_W-1:0]  deadline;
        logic [TIME_W-1:0]  period;
        logic               reload;
        logic               pending;
        logic [COUNT_W-1:0] count;
    } slot_rec_t;

    // Request context seen by the slot update unit
    typedef struct packed {
        kind_t             kind;
        logic              match;
        logic [TIME_W-1:0] period;
        logic              reload;
        logic [TIME_W-1:0] base;
    } req_ctx_t;

endpackage

FILE: hw/rtl/multi_slot_tick_task_scheduler_top.sv
// Top level of the multi-slot tick task scheduler: control, slot chain and result register.
//
// Usage:
//   Input stream s_*: s_tuser[1:0] is the request kind (tick, schedule, stop,
//   acknowledge); s_tdata carries slot number, period, auto-reload and offset.
//   Result stream m_*: one result per request with fired mask, pending mask,
//   the tick counter and the addressed slot's fire count.
//   The slot records sit in a ring of TASK_SLOTS cells. After a request is
//   taken the ring rotates one slot per cycle (the final step waits for a
//   free output register); each record passes the update unit at the ring
//   tail, so every slot is visited once. The result is registered at the
//   end of the walk; a new request is taken only after the walk has ended.
//   A result waiting in the output register does not block the next request;
//   if the receiver still stalls when the next walk ends, the ring holds on
//   its last step until the register frees.
//   Reset (aresetn low, synchronous): time zero, all slots disarmed, no
//   pending flags, counts zero, no result held.
module multi_slot_tick_task_scheduler_top #(
    parameter int TASK_SLOTS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // fields from bit 0: task_index[3:0], period_ms[35:4], auto_reload[36], offset_ms[68:37]
    input  logic [71:0] s_tdata,
    // fields from bit 0: kind[1:0]
    input  logic [1:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // fields from bit 0: fired_mask[15:0], pending_mask[31:16], current_time[63:32],
    // slot_fire_count[79:64]
    output logic [79:0] m_tdata
);

    localparam int SLOT_W = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
    localparam int TW = mstts_pkg::TIME_W;
    localparam int CW = mstts_pkg::COUNT_W;
    localparam int MW = mstts_pkg::MASK_W;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_RUN  = 2'b10
    } state_t;

    state_t state_reg, state_next;
    logic [SLOT_W-1:0] step_reg, step_next;
    logic [TW-1:0] now_reg, now_next;
    logic [TW-1:0] base_reg, base_next;
    mstts_pkg::kind_t kind_reg, kind_next;
    logic [mstts_pkg::IDX_W-1:0] idx_reg, idx_next;
    logic [TW-1:0] period_reg, period_next;
    logic reload_reg, reload_next;
    logic [MW-1:0] fired_reg, fired_next;
    logic [MW-1:0] pend_reg, pend_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic m_valid_reg, m_valid_next;
    logic [mstts_pkg::M_TDATA_W-1:0] m_data_reg, m_data_next;

    logic in_acc;
    logic last_step;
    logic out_free;
    logic shift_en;
    logic [SLOT_W-1:0] slot_id;
    logic [mstts_pkg::SLOT_CMP_W-1:0] slot_id_x;
    logic [TW-1:0] now_inc;
    logic upd_fired;
    mstts_pkg::req_ctx_t  ctx;
    mstts_pkg::slot_rec_t upd_rec;
    mstts_pkg::slot_rec_t chain_q [TASK_SLOTS];

    // Handshake and walk control
    assign s_tready  = (state_reg == ST_IDLE);
    assign in_acc    = s_tvalid && s_tready;
    assign last_step = (step_reg == SLOT_W'(TASK_SLOTS - 1));
    assign out_free  = !m_valid_reg || m_tready;
    assign shift_en  = (state_reg == ST_RUN) && (!last_step || out_free);

    // Slot at the ring tail: walk visits slots from the highest down
    assign slot_id   = SLOT_W'(TASK_SLOTS - 1) - step_reg;
    assign slot_id_x = mstts_pkg::SLOT_CMP_W'(slot_id);

    // Tick counter increment with wrap before all ones
    assign now_inc = (now_reg == mstts_pkg::ALL_ONES - 32'd1) ? '0 : now_reg + 32'd1;

    // Request context for the update unit
    always_comb begin
        ctx.kind   = kind_reg;
        ctx.match  = (mstts_pkg::SLOT_CMP_W'(idx_reg) == slot_id_x);
        ctx.period = period_reg;
        ctx.reload = reload_reg;
        ctx.base   = base_reg;
    end

    mstts_slot_upd u_upd (
        .ctx     (ctx),
        .rec_in  (chain_q[TASK_SLOTS-1]),
        .rec_out (upd_rec),
        .fired   (upd_fired)
    );

    // Slot ring: head takes the updated tail record, others take their neighbor
    genvar gi;
    generate
        for (gi = 0; gi < TASK_SLOTS; gi++) begin : g_chain
            if (gi == 0) begin : g_head
                mstts_cell u_cell (
                    .aclk     (aclk),
                    .aresetn  (aresetn),
                    .shift_en (shift_en),
                    .rec_in   (upd_rec),
                    .rec_q    (chain_q[gi])
                );
            end else begin : g_body
                mstts_cell u_cell (
                    .aclk     (aclk),
                    .aresetn  (aresetn),
                    .shift_en (shift_en),
                    .rec_in   (chain_q[gi-1]),
                    .rec_q    (chain_q[gi])
                );
            end
        end
    endgenerate

    // Next-state logic
    always_comb begin
        state_next   = state_reg;
        step_next    = step_reg;
        now_next     = now_reg;
        base_next    = base_reg;
        kind_next    = kind_reg;
        idx_next     = idx_reg;
        period_next  = period_reg;
        reload_next  = reload_reg;
        fired_next   = fired_reg;
        pend_next    = pend_reg;
        cnt_next     = cnt_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;

        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (in_acc) begin
                    kind_next   = mstts_pkg::kind_t'(s_tuser);
                    idx_next    = s_tdata[3:0];
                    period_next = s_tdata[35:4];
                    reload_next = s_tdata[36];
                    fired_next  = '0;
                    pend_next   = '0;
                    cnt_next    = '0;
                    step_next   = '0;
                    state_next  = ST_RUN;
                    if (mstts_pkg::kind_t'(s_tuser) == mstts_pkg::KIND_TICK) begin
                        now_next  = now_inc;
                        base_next = now_inc;
                    end else begin
                        base_next = now_reg + s_tdata[68:37];
                    end
                end
            end
            ST_RUN: begin
                if (shift_en) begin
                    // Collect this slot's result bits
                    if (slot_id_x < mstts_pkg::SLOT_CMP_W'(MW)) begin
                        fired_next[slot_id_x[3:0]] = upd_fired;
                        pend_next[slot_id_x[3:0]]  = upd_rec.pending;
                    end
                    if (ctx.match) begin
                        cnt_next = upd_rec.count;
                    end
                    step_next = step_reg + 1'b1;
                    if (last_step) begin
                        m_valid_next = 1'b1;
                        m_data_next  = {cnt_next, now_reg, pend_next, fired_next};
                        state_next   = ST_IDLE;
                        step_next    = '0;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            step_reg    <= '0;
            now_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            step_reg    <= step_next;
            now_reg     <= now_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        base_reg   <= base_next;
        kind_reg   <= kind_next;
        idx_reg    <= idx_next;
        period_reg <= period_next;
        reload_reg <= reload_next;
        fired_reg  <= fired_next;
        pend_reg   <= pend_next;
        cnt_reg    <= cnt_next;
        m_data_reg <= m_data_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    // Tick counter never reaches the disarmed code
    a_now_range: assert property (@(posedge aclk) disable iff (!aresetn)
        now_reg != mstts_pkg::ALL_ONES)
        else $error("tick counter reached all ones");

    // An accepted request always starts a walk
    a_acc_run: assert property (@(posedge aclk) disable iff (!aresetn)
        in_acc |=> (state_reg == ST_RUN) && (step_reg == '0))
        else $error("request accepted without starting a walk");

    // A new result only appears at the end of a walk
    a_res_walk: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(state_reg == ST_RUN) && $past(last_step))
        else $error("result produced outside the end of a walk");

    // Ring stays still while the result register blocks the final step
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_RUN) && last_step && m_valid_reg && !m_tready
        |=> (state_reg == ST_RUN) && $stable(step_reg))
        else $error("walk advanced while result register was full");

endmodule

FILE: hw/rtl/mstts_cell.sv
// One storage cell of the slot chain: holds a slot record, takes its neighbor's on a shift.
module mstts_cell (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 shift_en,
    input  mstts_pkg::slot_rec_t rec_in,
    output mstts_pkg::slot_rec_t rec_q
);

    mstts_pkg::slot_rec_t rec_reg;
    mstts_pkg::slot_rec_t rec_next;

    // Load neighbor record when the chain advances
    always_comb begin
        rec_next = shift_en ? rec_in : rec_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rec_reg.deadline <= mstts_pkg::ALL_ONES;
            rec_reg.period   <= '0;
            rec_reg.reload   <= 1'b0;
            rec_reg.pending  <= 1'b0;
            rec_reg.count    <= '0;
        end else begin
            rec_reg <= rec_next;
        end
    end

    assign rec_q = rec_reg;

endmodule

FILE: hw/rtl/mstts_slot_upd.sv
// Slot update unit: applies the current request to the record leaving the chain tail.
module mstts_slot_upd (
    input  mstts_pkg::req_ctx_t  ctx,
    input  mstts_pkg::slot_rec_t rec_in,
    output mstts_pkg::slot_rec_t rec_out,
    output logic                 fired
);

    logic [mstts_pkg::TIME_W-1:0] arm_p;
    logic [mstts_pkg::TIME_W-1:0] sum;
    logic [mstts_pkg::TIME_W-1:0] arm_dl;

    // Period used for (re)arming: stored one on a tick, all ones on a stop, requested one otherwise
    always_comb begin
        unique case (ctx.kind)
            mstts_pkg::KIND_TICK: arm_p = rec_in.period;
            mstts_pkg::KIND_STOP: arm_p = mstts_pkg::ALL_ONES;
            default:              arm_p = ctx.period;
        endcase
    end

    // New deadline; period zero or all ones disarms, a sum of all ones folds to zero
    always_comb begin
        sum = ctx.base + arm_p;
        if (arm_p == '0 || arm_p == mstts_pkg::ALL_ONES) begin
            arm_dl = mstts_pkg::ALL_ONES;
        end else if (sum == mstts_pkg::ALL_ONES) begin
            arm_dl = '0;
        end else begin
            arm_dl = sum;
        end
    end

    // Per-kind record update
    always_comb begin
        rec_out = rec_in;
        fired   = 1'b0;
        unique case (ctx.kind)
            mstts_pkg::KIND_TICK: begin
                if (rec_in.deadline == ctx.base) begin
                    rec_out.pending = 1'b1;
                    rec_out.count   = rec_in.count + 1'b1;
                    fired           = 1'b1;
                    rec_out.deadline = rec_in.reload ? arm_dl : mstts_pkg::ALL_ONES;
                end
            end
            mstts_pkg::KIND_SCHED: begin
                if (ctx.match) begin
                    rec_out.deadline = arm_dl;
                    rec_out.period   = ctx.period;
                    rec_out.reload   = ctx.reload;
                    if (ctx.period == '0) begin
                        rec_out.pending = 1'b1;
                        fired           = 1'b1;
                    end
                end
            end
            mstts_pkg::KIND_STOP: begin
                if (ctx.match) begin
                    rec_out.deadline = mstts_pkg::ALL_ONES;
                    rec_out.period   = mstts_pkg::ALL_ONES;
                    rec_out.reload   = 1'b0;
                end
            end
            mstts_pkg::KIND_ACK: begin
                if (ctx.match) begin
                    rec_out.pending = 1'b0;
                end
            end
            default: begin
                rec_out = rec_in;
            end
        endcase
    end

endmodule
